@@ design/rbs_pkg.sv @@
package rbs_pkg;

  localparam int unsigned QW       = 32;
  localparam int unsigned NW       = 33;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RqW      = NW + FracBits;
  localparam int unsigned DivSteps = RqW;
  localparam int unsigned Lanes    = 6;
  localparam int unsigned Axes     = 3;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5,
    REG_DIR_BIAS  = 3'd6
  } reg_idx_e;

  localparam logic signed [QW-1:0] QMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMin = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic [NW-1:0]  rem;
    logic [RqW-1:0] rq;
    logic [NW-1:0]  den;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [Lanes-1:0] lane;
    logic [Lanes-1:0]      neg;
    logic [Lanes-1:0]      nz;
    logic [QW-1:0]         limit;
  } div_item_t;

endpackage

@@ design/rbs_if.sv @@
interface rbs_ray_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [31:0] dir_x;
  logic [31:0] dir_y;
  logic [31:0] dir_z;
  logic [31:0] t_limit;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_limit,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_limit,
                output ready);
endinterface

interface rbs_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] t_entry;
  modport source (output valid, hit, t_entry, input ready);
  modport sink (input valid, hit, t_entry, output ready);
endinterface

interface rbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/rbs_div_cell.sv @@
module rbs_div_cell
  import rbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  div_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output div_item_t item_o
);

  logic      valid_q;
  div_item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    logic [NW:0] trial;
    logic        qbit;
    item_d = item_i;
    for (int l = 0; l < Lanes; l++) begin
      trial = {item_i.lane[l].rem, item_i.lane[l].rq[RqW-1]};
      qbit  = (trial >= {1'b0, item_i.lane[l].den});
      if (qbit) begin
        item_d.lane[l].rem = NW'(trial - {1'b0, item_i.lane[l].den});
      end else begin
        item_d.lane[l].rem = trial[NW-1:0];
      end
      item_d.lane[l].rq = {item_i.lane[l].rq[RqW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

@@ design/ray_box_slab_intersection.sv @@
// Channel | Dir | Beat contents
// ray_i   | in  | origin_x/y/z, dir_x/y/z, t_limit
// res_o   | out | hit, t_entry
// cfg_i   | in  | index, data (box_min_x..z, box_max_x..z, dir_bias)
// One ray per cycle sustained unless res_o stalls; one setup stage, 49 divider
// cells (one quotient bit per cell, six divisions side by side), two finish stages.
// Every stage holds its beat while the next is full and stalled; a bubble is filled.
// Reset clears all valid bits and loads the box with 0 and dir_bias with 1.
// cfg_i is always ready.
module ray_box_slab_intersection
  import rbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  rbs_ray_if.sink  ray_i,
  rbs_res_if.source res_o,
  rbs_cfg_if.sink  cfg_i
);

  logic [QW-1:0] box_q [Lanes];
  logic [15:0]   bias_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < Lanes; l++) box_q[l] <= '0;
      bias_q <= 16'd1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BOX_MIN_X: box_q[0] <= cfg_i.data;
        REG_BOX_MIN_Y: box_q[1] <= cfg_i.data;
        REG_BOX_MIN_Z: box_q[2] <= cfg_i.data;
        REG_BOX_MAX_X: box_q[3] <= cfg_i.data;
        REG_BOX_MAX_Y: box_q[4] <= cfg_i.data;
        REG_BOX_MAX_Z: box_q[5] <= cfg_i.data;
        REG_DIR_BIAS:  bias_q   <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // setup stage
  logic          prep_valid_q, prep_ready;
  div_item_t     prep_q, prep_d;
  logic [QW-1:0] org [Axes];
  logic [QW-1:0] dir [Axes];

  logic          cell_valid [DivSteps+1];
  logic          cell_ready [DivSteps+1];
  div_item_t     cell_item  [DivSteps+1];

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  always_comb begin
    logic [NW-1:0] num, den;
    prep_d = '0;
    for (int l = 0; l < Lanes; l++) begin
      num = NW'({box_q[l][QW-1], box_q[l]} - {org[l%Axes][QW-1], org[l%Axes]});
      den = NW'({dir[l%Axes][QW-1], dir[l%Axes]} + {17'd0, bias_q});
      prep_d.lane[l].rem = '0;
      prep_d.lane[l].rq  = {(num[NW-1] ? NW'(-num) : num), {FracBits{1'b0}}};
      prep_d.lane[l].den = den[NW-1] ? NW'(-den) : den;
      prep_d.neg[l]      = num[NW-1] ^ den[NW-1];
      prep_d.nz[l]       = (num != '0);
    end
    prep_d.limit = ray_i.t_limit;
  end

  assign prep_ready  = !prep_valid_q || cell_ready[0];
  assign ray_i.ready = prep_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (prep_ready) begin
      prep_valid_q <= ray_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ray_i.valid && prep_ready) begin
      prep_q <= prep_d;
    end
  end

  assign cell_valid[0] = prep_valid_q;
  assign cell_item[0]  = prep_q;

  for (genvar k = 0; k < DivSteps; k++) begin : g_cell
    rbs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[k]),
      .ready_o (cell_ready[k]),
      .item_i  (cell_item[k]),
      .valid_o (cell_valid[k+1]),
      .ready_i (cell_ready[k+1]),
      .item_o  (cell_item[k+1])
    );
  end

  // finish stage one: sign, saturate, order each slab
  logic                 fin_valid_q, fin_ready;
  logic signed [QW-1:0] lo_q [Axes], lo_d [Axes];
  logic signed [QW-1:0] hi_q [Axes], hi_d [Axes];
  logic signed [QW-1:0] lim_q;
  logic signed [QW-1:0] quo [Lanes];

  always_comb begin
    logic [RqW-1:0] mag;
    for (int l = 0; l < Lanes; l++) begin
      mag = cell_item[DivSteps].lane[l].rq;
      if (!cell_item[DivSteps].nz[l]) begin
        quo[l] = '0;
      end else if (cell_item[DivSteps].neg[l]) begin
        if (mag > RqW'(33'h80000000)) quo[l] = QMin;
        else quo[l] = QW'(-mag[QW-1:0]);
      end else begin
        if (mag > RqW'(32'h7FFFFFFF)) quo[l] = QMax;
        else quo[l] = mag[QW-1:0];
      end
    end
    for (int a = 0; a < Axes; a++) begin
      if (quo[a] > quo[a+Axes]) begin
        lo_d[a] = quo[a+Axes];
        hi_d[a] = quo[a];
      end else begin
        lo_d[a] = quo[a];
        hi_d[a] = quo[a+Axes];
      end
    end
  end

  logic res_valid_q, res_ready_int;

  assign fin_ready             = !fin_valid_q || res_ready_int;
  assign cell_ready[DivSteps]  = fin_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_ready) begin
      fin_valid_q <= cell_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_valid[DivSteps] && fin_ready) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      lim_q <= cell_item[DivSteps].limit;
    end
  end

  // finish stage two: entry, exit, hit
  logic signed [QW-1:0] entry, exit_t;
  logic                 hit_d, hit_q;
  logic [QW-1:0]        t_entry_q;

  always_comb begin
    entry  = lo_q[0];
    exit_t = hi_q[0];
    for (int a = 1; a < Axes; a++) begin
      if (lo_q[a] > entry)  entry  = lo_q[a];
      if (hi_q[a] < exit_t) exit_t = hi_q[a];
    end
    if (exit_t < entry) hit_d = 1'b0;
    else if (exit_t > 0) hit_d = !(entry > lim_q);
    else hit_d = !(entry < 0);
  end

  assign res_ready_int = !res_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready_int) begin
      res_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid_q && res_ready_int) begin
      hit_q     <= hit_d;
      t_entry_q <= entry;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.hit     = hit_q;
  assign res_o.t_entry = t_entry_q;

`ifndef NO_ASSERTIONS
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_i.ready)
    else $error("cfg port not ready");
  a_slab_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q |-> (lo_q[0] <= hi_q[0]) && (lo_q[1] <= hi_q[1]) && (lo_q[2] <= hi_q[2]))
    else $error("slab pair out of order");
  a_hit_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid_q && hit_d) |-> (entry <= exit_t))
    else $error("hit with empty span");
`endif

endmodule
